@@ hw/rtl/mwo_pkg.sv @@
// Shared constants, types and helper functions of the morphing wavetable oscillator.
// Used by every module under hw/rtl; depends on nothing else.
package mwo_pkg;

  localparam int VOICES         = 8;
  localparam int VOICE_BITS     = 3;
  localparam int TABLE_BITS     = 10;
  localparam int TABLE_POINTS   = 1 << TABLE_BITS;
  localparam int QUARTER        = TABLE_POINTS / 4;
  localparam int SINE_DEPTH     = QUARTER + 1;
  localparam int SINE_ADDR_BITS = TABLE_BITS - 1;
  localparam int SINE_SHIFT     = 32 - TABLE_BITS;
  localparam int TRI_SCALE      = 131072 / TABLE_POINTS;
  localparam int SAW_SCALE      = 65536 / TABLE_POINTS;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int MAG_W          = 15;

  localparam logic [31:0] STEP_RESET = 32'd24932051;

  // Odd polynomial for a quarter turn of sine, Q30.
  localparam logic signed [31:0] SIN_A1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_A3 = 32'sd693598668;
  localparam logic signed [31:0] SIN_A5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_A7 = 32'sd5026996;
  localparam logic signed [31:0] SIN_A9 = 32'sd172272;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_TRI    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_SAW    = 2'd3;

  localparam logic REG_SHAPE_MORPH = 1'b0;
  localparam logic REG_PHASE_STEP  = 1'b1;

  typedef struct packed {
    logic                      wr_en;
    logic [SINE_ADDR_BITS-1:0] wr_addr;
    logic [MAG_W-1:0]          wr_data;
    logic [SINE_ADDR_BITS-1:0] rd_addr;
  } sine_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end
    if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Table value of one waveform at one index; the sine magnitude comes from memory.
  function automatic logic signed [15:0] shape_value(input logic [1:0] wave,
                                                     input logic [TABLE_BITS-1:0] idx,
                                                     input logic [MAG_W-1:0] sine_mag);
    logic signed [18:0] pos;
    logic signed [18:0] v;
    pos = signed'(19'(idx));
    case (wave)
      WAVE_SINE: begin
        v = idx[TABLE_BITS-1] ? -signed'(19'(sine_mag)) : signed'(19'(sine_mag));
      end
      WAVE_TRI: begin
        if (pos < QUARTER) begin
          v = 19'(pos * TRI_SCALE);
        end else if (pos < 3 * QUARTER) begin
          v = 19'((2 * QUARTER - pos) * TRI_SCALE);
        end else begin
          v = 19'((pos - TABLE_POINTS) * TRI_SCALE);
        end
      end
      WAVE_SQUARE: begin
        v = idx[TABLE_BITS-1] ? -19'sd32768 : 19'sd32767;
      end
      WAVE_SAW: begin
        v = 19'((2 * QUARTER - pos) * SAW_SCALE);
      end
      default: begin
        v = '0;
      end
    endcase
    return sat16(v);
  endfunction

  // Product divided by 2^30, truncated toward zero.
  function automatic logic signed [35:0] q30_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [35:0] q;
    q = p[PROD_W-1:30];
    if (p[PROD_W-1] && (p[29:0] != '0)) begin
      q = q + 36'sd1;
    end
    return q;
  endfunction

  // Q30 sine value to a Q15 magnitude, rounded half up and clamped.
  function automatic logic [MAG_W-1:0] sine_round(input logic signed [35:0] s);
    logic [35:0] r;
    if (s[35]) begin
      return '0;
    end
    r = (36'(s) + 36'd16384) >> 15;
    if (r > 36'd32767) begin
      return 15'h7FFF;
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic logic signed [31:0] horner_coef(input logic [2:0] step);
    case (step)
      3'd1:    return -SIN_A7;
      3'd2:    return SIN_A5;
      3'd3:    return -SIN_A3;
      3'd4:    return SIN_A1;
      default: return '0;
    endcase
  endfunction

endpackage

@@ hw/rtl/mwo_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on mwo_pkg for operand widths.
module mwo_mul
  import mwo_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hw/rtl/mwo_sine_mem.sv @@
// Quarter-wave sine magnitude memory, one write and one registered read port.
// Depends on mwo_pkg for its depth and the control struct.
module mwo_sine_mem
  import mwo_pkg::*;
(
  input  logic             clk,
  input  sine_ctrl_t       ctrl,
  output logic [MAG_W-1:0] rd_data
);

  logic [MAG_W-1:0] mem [SINE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_data <= mem[ctrl.rd_addr];
  end

endmodule

@@ hw/rtl/morphing_wavetable_oscillator.sv @@
// Eight-voice morphing wavetable oscillator, top level with its sequencer.
// Depends on mwo_pkg, mwo_mul and mwo_sine_mem.
//
// Each request is one sample tick of one voice and yields one sample. After reset the
// block builds its quarter-wave sine memory, 257 points, with item_stall high
// (configuration writes are taken meanwhile). A tick of a resting voice skips the
// phase, fetch, blend and scaling steps. A sounding tick is paced by the single 33x33
// multiplier, which every step of the increment, phase and waveform blends and velocity
// scaling goes through, and by the one read port of the sine memory, which serves the
// four table taps one per cycle.
// A finished sample waits in the output register while the next request is taken.
// Configuration registers should only be written while no request is in flight.
module morphing_wavetable_oscillator
  import mwo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [VOICE_BITS-1:0] voice,
  input  logic                  segment_start,
  input  logic                  note_onset,
  input  logic [23:0]           pitch,
  input  logic [15:0]           velocity,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [15:0]    sample,
  output logic                  sounding
);

  typedef enum logic [14:0] {
    ST_FILL_MUL = 15'b000000000000001,
    ST_FILL_ACC = 15'b000000000000010,
    ST_IDLE     = 15'b000000000000100,
    ST_INC      = 15'b000000000001000,
    ST_PHASE    = 15'b000000000010000,
    ST_FETCH    = 15'b000000000100000,
    ST_VA_MUL   = 15'b000000001000000,
    ST_VB_MUL   = 15'b000000010000000,
    ST_VB_GET   = 15'b000000100000000,
    ST_MIX_MUL  = 15'b000001000000000,
    ST_MIX_GET  = 15'b000010000000000,
    ST_LO_MUL   = 15'b000100000000000,
    ST_HI_MUL   = 15'b001000000000000,
    ST_SUM      = 15'b010000000000000,
    ST_OUT      = 15'b100000000000000
  } state_t;

  localparam logic [2:0]  FILL_LAST  = 3'd5;
  localparam logic [2:0]  FETCH_LAST = 3'd4;
  localparam logic [57:0] ROUND_HALF = 58'd1 << 38;

  state_t state;

  logic [9:0]  shape_morph;
  logic [31:0] phase_step;

  logic [31:0] phase_acc     [VOICES];
  logic [23:0] held_pitch    [VOICES];
  logic [15:0] held_velocity [VOICES];

  logic [SINE_ADDR_BITS-1:0] fill_k;
  logic [2:0]                fill_step;
  logic signed [31:0]        horner_t;
  logic signed [31:0]        fill_u2;

  logic [VOICE_BITS-1:0] cur_voice;
  logic [23:0]           cur_pitch;
  logic [15:0]           cur_vel;
  logic [31:0]           cur_phase;

  logic [2:0]         fetch_cnt;
  logic signed [15:0] tap [4];
  logic signed [31:0] va;
  logic signed [31:0] vb;
  logic signed [39:0] mix;
  logic [31:0]        lo_prod;
  logic signed [15:0] res_sample;
  logic               res_sounding;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  sine_ctrl_t               sine_ctrl;
  logic [MAG_W-1:0]         sine_rd;

  logic                      seg_take;
  logic                      out_free;
  logic signed [35:0]        fill_q;
  logic signed [MUL_W-1:0]   fill_u;
  logic [31:0]               phase_next;
  logic [TABLE_BITS-1:0]     idx1;
  logic [TABLE_BITS-1:0]     idx2;
  logic [15:0]               frac;
  logic [1:0]                wave_a;
  logic [1:0]                wave_b;
  logic [7:0]                weight;
  logic [1:0]                issue_j;
  logic [TABLE_BITS-1:0]     issue_idx;
  logic [SINE_ADDR_BITS-1:0] issue_k;
  logic [2:0]                cap_cnt;
  logic [1:0]                cap_j;
  logic [TABLE_BITS-1:0]     cap_idx;
  logic [1:0]                cap_wave;
  logic signed [16:0]        diff_a;
  logic signed [16:0]        diff_b;
  logic signed [32:0]        diff_mix;
  logic signed [57:0]        total;

  mwo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mwo_sine_mem u_sine_mem (
    .clk     (clk),
    .ctrl    (sine_ctrl),
    .rd_data (sine_rd)
  );

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // A new segment retriggers the voice on an onset or on a real pitch change.
  assign seg_take = segment_start &&
                    (note_onset || (pitch != '0 && pitch != held_pitch[voice]));

  assign fill_q     = q30_trunc(prod);
  assign fill_u     = MUL_W'(fill_k) << SINE_SHIFT;
  assign phase_next = cur_phase + prod[47:16];

  assign idx1   = cur_phase[31 -: TABLE_BITS];
  assign idx2   = idx1 + TABLE_BITS'(1);
  assign frac   = cur_phase[31-TABLE_BITS -: 16];
  assign wave_a = shape_morph[9:8];
  assign wave_b = wave_a + 2'd1;
  assign weight = shape_morph[7:0];

  // Taps in order: wave A at idx1 and idx2, then wave B at idx1 and idx2.
  assign issue_j   = fetch_cnt[1:0];
  assign issue_idx = issue_j[0] ? idx2 : idx1;
  assign issue_k   = issue_idx[TABLE_BITS-2] ?
                     SINE_ADDR_BITS'(QUARTER) - SINE_ADDR_BITS'(issue_idx[TABLE_BITS-3:0]) :
                     SINE_ADDR_BITS'(issue_idx[TABLE_BITS-3:0]);
  assign cap_cnt   = fetch_cnt - 3'd1;
  assign cap_j     = cap_cnt[1:0];
  assign cap_idx   = cap_j[0] ? idx2 : idx1;
  assign cap_wave  = cap_j[1] ? wave_b : wave_a;

  assign diff_a   = 17'(tap[1]) - 17'(tap[0]);
  assign diff_b   = 17'(tap[3]) - 17'(tap[2]);
  assign diff_mix = 33'(vb) - 33'(va);
  assign total    = (58'(signed'(prod[39:0])) <<< 16) + 58'(lo_prod) + ROUND_HALF;

  always_comb begin
    sine_ctrl.wr_en   = (state == ST_FILL_ACC) && (fill_step == FILL_LAST);
    sine_ctrl.wr_addr = fill_k;
    sine_ctrl.wr_data = sine_round(fill_q);
    sine_ctrl.rd_addr = issue_k;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FILL_MUL: begin
        if (fill_step == 3'd0) begin
          mul_a = fill_u;
          mul_b = fill_u;
        end else if (fill_step == FILL_LAST) begin
          mul_a = MUL_W'(horner_t);
          mul_b = fill_u;
        end else begin
          mul_a = MUL_W'(horner_t);
          mul_b = MUL_W'(fill_u2);
        end
      end
      ST_INC: begin
        mul_a = MUL_W'(cur_pitch);
        mul_b = MUL_W'(phase_step);
      end
      ST_VA_MUL: begin
        mul_a = MUL_W'(diff_a);
        mul_b = MUL_W'(frac);
      end
      ST_VB_MUL: begin
        mul_a = MUL_W'(diff_b);
        mul_b = MUL_W'(frac);
      end
      ST_MIX_MUL: begin
        mul_a = diff_mix;
        mul_b = MUL_W'(weight);
      end
      ST_LO_MUL: begin
        mul_a = MUL_W'(mix[15:0]);
        mul_b = MUL_W'(cur_vel);
      end
      ST_HI_MUL: begin
        mul_a = MUL_W'(signed'(mix[39:16]));
        mul_b = MUL_W'(cur_vel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control: sequencer, counters, configuration and per-voice state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL_MUL;
      fill_k       <= '0;
      fill_step    <= '0;
      fetch_cnt    <= '0;
      shape_morph  <= '0;
      phase_step   <= STEP_RESET;
      result_valid <= 1'b0;
      for (int n = 0; n < VOICES; n++) begin
        phase_acc[n]     <= '0;
        held_pitch[n]    <= '0;
        held_velocity[n] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SHAPE_MORPH: shape_morph <= cfg_data[9:0];
          REG_PHASE_STEP:  phase_step  <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        ST_FILL_MUL: state <= ST_FILL_ACC;
        ST_FILL_ACC: begin
          if (fill_step == FILL_LAST) begin
            fill_step <= '0;
            if (fill_k == SINE_ADDR_BITS'(QUARTER)) begin
              state <= ST_IDLE;
            end else begin
              fill_k <= fill_k + SINE_ADDR_BITS'(1);
              state  <= ST_FILL_MUL;
            end
          end else begin
            fill_step <= fill_step + 3'd1;
            state     <= ST_FILL_MUL;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_INC;
            if (seg_take) begin
              phase_acc[voice]     <= '0;
              held_pitch[voice]    <= pitch;
              held_velocity[voice] <= velocity;
            end
          end
        end
        ST_INC: state <= (cur_pitch == '0) ? ST_OUT : ST_PHASE;
        ST_PHASE: begin
          phase_acc[cur_voice] <= phase_next;
          fetch_cnt            <= '0;
          state                <= ST_FETCH;
        end
        ST_FETCH: begin
          if (fetch_cnt == FETCH_LAST) begin
            state <= ST_VA_MUL;
          end else begin
            fetch_cnt <= fetch_cnt + 3'd1;
          end
        end
        ST_VA_MUL:  state <= ST_VB_MUL;
        ST_VB_MUL:  state <= ST_VB_GET;
        ST_VB_GET:  state <= ST_MIX_MUL;
        ST_MIX_MUL: state <= ST_MIX_GET;
        ST_MIX_GET: state <= ST_LO_MUL;
        ST_LO_MUL:  state <= ST_HI_MUL;
        ST_HI_MUL:  state <= ST_SUM;
        ST_SUM:     state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (state == ST_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_FILL_ACC: begin
        if (fill_step == 3'd0) begin
          fill_u2  <= fill_q[31:0];
          horner_t <= SIN_A9;
        end else begin
          horner_t <= fill_q[31:0] + horner_coef(fill_step);
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cur_voice <= voice;
          cur_pitch <= seg_take ? pitch : held_pitch[voice];
          cur_vel   <= seg_take ? velocity : held_velocity[voice];
          cur_phase <= seg_take ? '0 : phase_acc[voice];
        end
      end
      ST_INC: begin
        res_sample   <= '0;
        res_sounding <= 1'b0;
      end
      ST_PHASE: cur_phase <= phase_next;
      ST_FETCH: begin
        if (fetch_cnt != 3'd0) begin
          tap[cap_j] <= shape_value(cap_wave, cap_idx, sine_rd);
        end
      end
      ST_VB_MUL:  va      <= {tap[0], 16'b0} + prod[31:0];
      ST_VB_GET:  vb      <= {tap[2], 16'b0} + prod[31:0];
      ST_MIX_GET: mix     <= {va, 8'b0} + prod[39:0];
      ST_HI_MUL:  lo_prod <= prod[31:0];
      ST_SUM: begin
        res_sample   <= sat16(signed'(total[57:39]));
        res_sounding <= 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          sample   <= res_sample;
          sounding <= res_sounding;
        end
      end
      default: begin
      end
    endcase
  end

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_OUT)
    else $error("result raised without passing the output state");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_k <= SINE_ADDR_BITS'(QUARTER))
    else $error("sine build address ran past the quarter wave");

  a_sounding_pitch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && res_sounding) |-> cur_pitch != '0)
    else $error("sounding result for a resting voice");

endmodule

@@ bench/tb_morphing_wavetable_oscillator.sv @@
// Self-checking testbench for the morphing wavetable oscillator.
// Predicts every sample from its own copy of voice state and waveform tables;
// needs mwo_pkg and morphing_wavetable_oscillator, with mwo_mul and mwo_sine_mem below it.
`timescale 1ns / 100ps

module tb_morphing_wavetable_oscillator;
  import mwo_pkg::*;

  typedef struct packed {
    logic [VOICE_BITS-1:0] voice;
    logic                  segment_start;
    logic                  note_onset;
    logic [23:0]           pitch;
    logic [15:0]           velocity;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sounding;
  } voice_out_t;

  localparam longint Q30_UNIT = 64'sd1073741824;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic                  cfg_index = REG_SHAPE_MORPH;
  logic [31:0]           cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [VOICE_BITS-1:0] voice = '0;
  logic                  segment_start = 1'b0;
  logic                  note_onset = 1'b0;
  logic [23:0]           pitch = '0;
  logic [15:0]           velocity = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic signed [15:0]    sample;
  logic                  sounding;

  morphing_wavetable_oscillator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .voice        (voice),
    .segment_start(segment_start),
    .note_onset   (note_onset),
    .pitch        (pitch),
    .velocity     (velocity),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .sounding     (sounding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: settings, per-voice oscillator state and the four waveforms.
  logic [9:0]         morph_setting = '0;
  logic [31:0]        step_setting = STEP_RESET;
  logic [31:0]        voice_phase [VOICES];
  logic [23:0]        voice_pitch [VOICES];
  logic [15:0]        voice_level [VOICES];
  logic signed [15:0] shape_rom [0:4*TABLE_POINTS-1];

  tick_t      tick_backlog [$];
  voice_out_t sample_forecast [$];
  int         requests_open = 0;
  int         mismatch_count = 0;
  logic [23:0] score_pitch [VOICES];

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic longint sine_point(input logic [31:0] p);
    longint u, u2, t, s, q;
    u = longint'(p[29:0]);
    if (p[30]) begin
      u = Q30_UNIT - u;
    end
    u2 = (u * u) / Q30_UNIT;
    t = 64'sd172272;
    t = (t * u2) / Q30_UNIT - 64'sd5026996;
    t = (t * u2) / Q30_UNIT + 64'sd85569306;
    t = (t * u2) / Q30_UNIT - 64'sd693598668;
    t = (t * u2) / Q30_UNIT + 64'sd1686629713;
    s = (t * u) / Q30_UNIT;
    if (s < 0) begin
      s = 0;
    end
    q = (s + 16384) / 32768;
    if (q > 32767) begin
      q = 32767;
    end
    return p[31] ? -q : q;
  endfunction

  function automatic logic signed [15:0] table_point(input int w, input int i);
    longint n, k, v;
    n = longint'(TABLE_POINTS);
    k = longint'(i);
    case (w)
      WAVE_SINE: begin
        v = sine_point(32'(i) << (32 - TABLE_BITS));
      end
      WAVE_TRI: begin
        if (4 * k < n) begin
          v = (4 * k * 32768) / n;
        end else if (4 * k < 3 * n) begin
          v = ((2 * n - 4 * k) * 32768) / n;
        end else begin
          v = ((4 * k - 4 * n) * 32768) / n;
        end
      end
      WAVE_SQUARE: begin
        v = (2 * k < n) ? 32767 : -32768;
      end
      default: begin
        v = ((n - 2 * k) * 32768) / n;
      end
    endcase
    return clamp16(v);
  endfunction

  // Advances one voice by one tick and returns the sample it should produce.
  function automatic voice_out_t advance_voice(input tick_t t);
    voice_out_t r;
    logic [63:0] prod;
    logic [31:0] inc;
    int          i1, i2, wa, wb;
    longint      f, wl, a1, a2, b1, b2, va, vb, mix;
    r.sample = '0;
    r.sounding = 1'b0;
    if (t.segment_start && (t.note_onset ||
        (t.pitch != 0 && t.pitch != voice_pitch[t.voice]))) begin
      voice_phase[t.voice] = '0;
      voice_pitch[t.voice] = t.pitch;
      voice_level[t.voice] = t.velocity;
    end
    if (voice_pitch[t.voice] != 0) begin
      prod = 64'(voice_pitch[t.voice]) * 64'(step_setting);
      inc = prod[47:16];
      voice_phase[t.voice] = voice_phase[t.voice] + inc;
      i1 = int'(voice_phase[t.voice][31:32-TABLE_BITS]);
      i2 = (i1 + 1) % TABLE_POINTS;
      f = longint'(voice_phase[t.voice][31-TABLE_BITS:16-TABLE_BITS]);
      wa = int'(morph_setting[9:8]);
      wb = (wa + 1) % 4;
      wl = longint'(morph_setting[7:0]);
      a1 = longint'(shape_rom[wa * TABLE_POINTS + i1]);
      a2 = longint'(shape_rom[wa * TABLE_POINTS + i2]);
      b1 = longint'(shape_rom[wb * TABLE_POINTS + i1]);
      b2 = longint'(shape_rom[wb * TABLE_POINTS + i2]);
      va = a1 * (65536 - f) + a2 * f;
      vb = b1 * (65536 - f) + b2 * f;
      mix = va * (256 - wl) + vb * wl;
      // Round half up from Q54 to Q15; the arithmetic shift floors.
      r.sample = clamp16((mix * longint'(voice_level[t.voice]) + 64'sd274877906944) >>> 39);
      r.sounding = 1'b1;
    end
    return r;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  tick_t live_tick;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        sample_forecast = {sample_forecast, advance_voice(live_tick)};
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (tick_backlog.size() > 0) begin
          live_tick = tick_backlog.pop_front();
          voice <= live_tick.voice;
          segment_start <= live_tick.segment_start;
          note_onset <= live_tick.note_onset;
          pitch <= live_tick.pitch;
          velocity <= live_tick.velocity;
          item_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    voice_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (sample_forecast.size() == 0) begin
          $display("%0t: result with no request pending: sample %0d sounding %0d",
                   $time, sample, sounding);
          mismatch_count++;
        end else begin
          want = sample_forecast.pop_front();
          requests_open--;
          if (sample !== want.sample) begin
            $display("%0t: sample mismatch: expected %0d actual %0d",
                     $time, want.sample, sample);
            mismatch_count++;
          end
          if (sounding !== want.sounding) begin
            $display("%0t: sounding mismatch: expected %0d actual %0d",
                     $time, want.sounding, sounding);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(10, 60);
      end
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  task automatic queue_tick(input int v, input logic seg, input logic onset,
                            input logic [23:0] p, input logic [15:0] vel);
    tick_t t;
    t.voice = VOICE_BITS'(v);
    t.segment_start = seg;
    t.note_onset = onset;
    t.pitch = p;
    t.velocity = vel;
    if (seg && (onset || (p != 0 && p != score_pitch[v]))) begin
      score_pitch[v] = p;
    end
    requests_open++;
    tick_backlog = {tick_backlog, t};
  endtask

  function automatic logic [23:0] pick_pitch();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 24'($urandom_range(20 << 8, 5000 << 8));
    end else if (roll < 85) begin
      return 24'($urandom);
    end else if (roll < 95) begin
      return 24'($urandom_range(1, 255));
    end
    return 24'hFFFFFF;
  endfunction

  function automatic logic [15:0] pick_velocity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 16'($urandom_range(0, 32768));
    end else if (roll < 75) begin
      return 16'h8000;
    end else if (roll < 85) begin
      return '0;
    end
    return 16'($urandom);
  endfunction

  // Mostly note sequences per voice; segment-free ticks carry junk pitch and velocity.
  task automatic queue_music(input int count);
    int v, roll;
    repeat (count) begin
      v = $urandom_range(0, VOICES - 1);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        queue_tick(v, 1'b1, 1'b1, pick_pitch(), pick_velocity());
      end else if (roll < 18) begin
        queue_tick(v, 1'b1, 1'b0, pick_pitch(), pick_velocity());
      end else if (roll < 21) begin
        queue_tick(v, 1'b1, 1'b0, score_pitch[v], pick_velocity());
      end else if (roll < 24) begin
        queue_tick(v, 1'b1, 1'b0, 24'd0, pick_velocity());
      end else if (roll < 26) begin
        queue_tick(v, 1'b1, 1'b1, 24'd0, pick_velocity());
      end else begin
        queue_tick(v, 1'b0, 1'($urandom_range(0, 1)), 24'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_SHAPE_MORPH) begin
      morph_setting = val[9:0];
    end else begin
      step_setting = val;
    end
  endtask

  task automatic wait_idle();
    while (requests_open != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] morph, input logic [31:0] step,
                           input int count);
    wait_idle();
    write_reg(REG_SHAPE_MORPH, morph);
    write_reg(REG_PHASE_STEP, step);
    queue_music(count);
  endtask

  initial begin
    for (int k = 0; k < 4 * TABLE_POINTS; k++) begin
      shape_rom[k] = table_point(k / TABLE_POINTS, k % TABLE_POINTS);
    end
    for (int k = 0; k < VOICES; k++) begin
      voice_phase[k] = '0;
      voice_pitch[k] = '0;
      voice_level[k] = '0;
      score_pitch[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Pure sine at the default step; registers are taken during the table build.
    write_reg(REG_SHAPE_MORPH, 32'd0);
    write_reg(REG_PHASE_STEP, STEP_RESET);
    queue_tick(0, 1'b0, 1'b0, 24'd0, 16'd0);              // nothing held yet
    queue_tick(0, 1'b1, 1'b1, 24'd440 << 8, 16'h8000);
    queue_tick(0, 1'b0, 1'b1, 24'hFFFFFF, 16'hFFFF);      // fields ignored mid-segment
    queue_tick(0, 1'b1, 1'b0, 24'd440 << 8, 16'd100);     // same pitch, no retrigger
    queue_tick(0, 1'b1, 1'b0, 24'd0, 16'd5);              // zero pitch legato is ignored
    queue_tick(0, 1'b1, 1'b0, 24'd880 << 8, 16'h4000);    // new pitch retriggers
    queue_tick(0, 1'b1, 1'b1, 24'd880 << 8, 16'h8000);    // onset retriggers same pitch
    queue_tick(0, 1'b1, 1'b1, 24'd0, 16'h8000);           // struck rest
    queue_tick(0, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(7, 1'b1, 1'b1, 24'hFFFFFF, 16'hFFFF);      // top pitch, velocity past full scale
    queue_tick(7, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(7, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(7, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(3, 1'b1, 1'b1, 24'd1, 16'd0);
    queue_tick(3, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(5, 1'b1, 1'b1, 24'd12000 << 8, 16'h8000);
    repeat (4) queue_tick(5, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_tick(1, 1'b1, 1'b1, 24'h800000, 16'h7FFF);
    queue_tick(1, 1'b0, 1'b0, 24'd0, 16'd0);
    queue_music(95);

    run_phase(32'd768, $urandom, 95);                     // pure down saw
    run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 95);            // saw toward sine, largest step
    run_phase(32'h0FF, 32'd0, 60);                        // phase never moves
    run_phase(32'h180, 32'h4000_0000, 95);
    run_phase(32'h2C0, STEP_RESET, 95);
    run_phase($urandom_range(0, 1023), $urandom, 95);

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && sample_forecast.size() == 0) begin
      $display("tb_morphing_wavetable_oscillator: done, clean");
    end else begin
      $display("tb_morphing_wavetable_oscillator: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_morphing_wavetable_oscillator: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mwo_pkg.sv
hw/rtl/mwo_mul.sv
hw/rtl/mwo_sine_mem.sv
hw/rtl/morphing_wavetable_oscillator.sv
bench/tb_morphing_wavetable_oscillator.sv
